// ===== hdl/whpc_pkg.sv =====
// whpc_pkg: shared types and constants of the water heater power controller
// sequencer states, multiplier operand selects, control struct, register indexes
// no dependencies
package whpc_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PID_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_VOLTAGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 3'd5;

  // stream widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;

  // datapath widths
  localparam int A_W    = 19;  // shared multiplier operand a, signed
  localparam int WK_W   = 24;  // pid working width, signed
  localparam int ACC_W  = 18;  // saturated flow times rise
  localparam int TOP_W  = 14;  // limit times 100

  // constants
  localparam logic [6:0]          POWER_MAX    = 7'd100;
  localparam logic [6:0]          OFFSET_MAX   = 7'd80;
  localparam logic [7:0]          CEIL_BIAS    = 8'd18;
  localparam logic signed [10:0]  RISE_MIN     = 11'sd10;
  localparam logic signed [10:0]  BAND_PID     = -11'sd15;
  localparam logic signed [10:0]  BAND_FF      = -11'sd45;
  localparam int                  RECIP_100    = 5243;  // 2^19 / 100, rounded up
  localparam int                  RECIP_SHIFT  = 19;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FLOW,
    ST_GAIN_P,
    ST_COEF,
    ST_GAIN_I,
    ST_GAIN_D,
    ST_SUM,
    ST_RECIP,
    ST_PID,
    ST_OFFSET,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    MS_FLOW,
    MS_GAIN_P,
    MS_COEF,
    MS_GAIN_I,
    MS_GAIN_D,
    MS_RECIP
  } mul_sel_e;

  typedef struct packed {
    logic     in_ready;
    mul_sel_e mul_sel;
    logic     ld_acc;
    logic     ld_prop;
    logic     ld_term;
    logic     ld_integ;
    logic     ld_total;
    logic     ld_pid;
    logic     ld_off;
    logic     ld_out;
  } ctrl_t;

endpackage

// ===== hdl/whpc_mul.sv =====
// whpc_mul: shared signed multiplier with registered product
// used for the products of the sequenced steps; no package dependency
module whpc_mul #(
  parameter int A_W = 19,
  parameter int B_W = 16
) (
  input  logic                     clk_i,
  input  logic signed [A_W-1:0]    op_a_i,
  input  logic signed [B_W-1:0]    op_b_i,
  output logic signed [A_W+B_W-1:0] prod_o
);

  logic signed [A_W+B_W-1:0] prod_q;
  logic signed [A_W+B_W-1:0] prod_d;

  assign prod_d = op_a_i * op_b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ===== hdl/whpc_seq.sv =====
// whpc_seq: step sequencer of the controller
// drives operand selects and register loads; uses whpc_pkg
module whpc_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            pid_en_i,
  input  logic            out_busy_i,
  output whpc_pkg::ctrl_t ctrl_o
);

  whpc_pkg::state_e state_q;
  whpc_pkg::state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= whpc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      whpc_pkg::ST_IDLE: begin
        if (start_i) state_d = whpc_pkg::ST_FLOW;
      end
      whpc_pkg::ST_FLOW:   state_d = whpc_pkg::ST_GAIN_P;
      whpc_pkg::ST_GAIN_P: state_d = whpc_pkg::ST_COEF;
      whpc_pkg::ST_COEF:   state_d = whpc_pkg::ST_GAIN_I;
      whpc_pkg::ST_GAIN_I: begin
        state_d = pid_en_i ? whpc_pkg::ST_GAIN_D : whpc_pkg::ST_OFFSET;
      end
      whpc_pkg::ST_GAIN_D: state_d = whpc_pkg::ST_SUM;
      whpc_pkg::ST_SUM:    state_d = whpc_pkg::ST_RECIP;
      whpc_pkg::ST_RECIP:  state_d = whpc_pkg::ST_PID;
      whpc_pkg::ST_PID:    state_d = whpc_pkg::ST_OFFSET;
      whpc_pkg::ST_OFFSET: state_d = whpc_pkg::ST_OUT;
      whpc_pkg::ST_OUT: begin
        if (!out_busy_i) state_d = whpc_pkg::ST_IDLE;
      end
      default: state_d = whpc_pkg::ST_IDLE;
    endcase
  end

  // from flow to pid, each step loads the product of the previous step, issues the next one, or both
  always_comb begin
    ctrl_o         = '0;
    ctrl_o.mul_sel = whpc_pkg::MS_FLOW;
    case (state_q)
      whpc_pkg::ST_IDLE:   ctrl_o.in_ready = 1'b1;
      whpc_pkg::ST_FLOW:   ctrl_o.mul_sel = whpc_pkg::MS_FLOW;
      whpc_pkg::ST_GAIN_P: begin
        ctrl_o.mul_sel = whpc_pkg::MS_GAIN_P;
        ctrl_o.ld_acc  = 1'b1;
      end
      whpc_pkg::ST_COEF: begin
        ctrl_o.mul_sel = whpc_pkg::MS_COEF;
        ctrl_o.ld_prop = 1'b1;
      end
      whpc_pkg::ST_GAIN_I: begin
        ctrl_o.mul_sel = whpc_pkg::MS_GAIN_I;
        ctrl_o.ld_term = 1'b1;
      end
      whpc_pkg::ST_GAIN_D: begin
        ctrl_o.mul_sel  = whpc_pkg::MS_GAIN_D;
        ctrl_o.ld_integ = 1'b1;
      end
      whpc_pkg::ST_SUM:    ctrl_o.ld_total = 1'b1;
      whpc_pkg::ST_RECIP:  ctrl_o.mul_sel = whpc_pkg::MS_RECIP;
      whpc_pkg::ST_PID:    ctrl_o.ld_pid = 1'b1;
      whpc_pkg::ST_OFFSET: ctrl_o.ld_off = 1'b1;
      whpc_pkg::ST_OUT:    ctrl_o.ld_out = !out_busy_i;
      default: ctrl_o = '0;
    endcase
  end

endmodule

// ===== hdl/water_heater_power_controller.sv =====
// water_heater_power_controller: feedforward offset plus deadbanded pid trim
// one item at a time; the single shared multiplier
//   takes up to six products one per step, and input is taken again once the result is out
// reset: asynchronous active low, clears offset, ceiling, pid state and config to defaults
// uses whpc_pkg, whpc_seq, whpc_mul
module water_heater_power_controller #(
  parameter int COEF_FRAC_BITS = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // setpoint[9:0], inlet_temp[19:10], outlet_temp[29:20], water_flow[44:30],
  // flow_slope[60:45], zero fill
  input  logic [whpc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // heater_power[6:0], offset_level[13:7], zero fill
  output logic [whpc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic [whpc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [whpc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  // feedforward coefficients in the chosen fixed point
  localparam longint unsigned COEF_HI_L =
    (64'd103 * (64'd1 << COEF_FRAC_BITS) + 64'd50000) / 64'd100000;
  localparam longint unsigned COEF_LO_L =
    (64'd65 * (64'd1 << COEF_FRAC_BITS) + 64'd50000) / 64'd100000;
  localparam longint unsigned CST_HI_L  = 64'd13 << (COEF_FRAC_BITS - 1);
  localparam longint unsigned CST_LO_L  = 64'd15 << (COEF_FRAC_BITS - 1);
  localparam int COEF_W = $clog2(COEF_HI_L + 1);
  localparam int B_W    = ((COEF_W > 13) ? COEF_W : 13) + 1;
  localparam int P_W    = whpc_pkg::A_W + B_W;
  localparam int TS_W   = P_W + 1;

  localparam logic [B_W-1:0]  COEF_HI = B_W'(COEF_HI_L);
  localparam logic [B_W-1:0]  COEF_LO = B_W'(COEF_LO_L);
  localparam logic [TS_W-1:0] CST_HI  = TS_W'(CST_HI_L);
  localparam logic [TS_W-1:0] CST_LO  = TS_W'(CST_LO_L);

  whpc_pkg::ctrl_t ctrl;

  // configuration
  logic       pid_en_q, low_volt_q;
  logic [7:0] gain_p_q, gain_i_q, gain_d_q;
  logic [5:0] dead_zone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pid_en_q    <= 1'b0;
      low_volt_q  <= 1'b0;
      gain_p_q    <= 8'd25;
      gain_i_q    <= 8'd2;
      gain_d_q    <= 8'd100;
      dead_zone_q <= 6'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        whpc_pkg::CFG_PID_ENABLE:  pid_en_q    <= cfg_data_i[0];
        whpc_pkg::CFG_LOW_VOLTAGE: low_volt_q  <= cfg_data_i[0];
        whpc_pkg::CFG_GAIN_P:      gain_p_q    <= cfg_data_i;
        whpc_pkg::CFG_GAIN_I:      gain_i_q    <= cfg_data_i;
        whpc_pkg::CFG_GAIN_D:      gain_d_q    <= cfg_data_i;
        whpc_pkg::CFG_DEAD_ZONE:   dead_zone_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // input capture
  logic               in_xfer;
  logic [9:0]         sp, tin, tout;
  logic [15:0]        slope;
  logic signed [16:0] slope_adj;
  logic signed [10:0] err_d, rise_d;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign sp        = s_axis_tdata[9:0];
  assign tin       = s_axis_tdata[19:10];
  assign tout      = s_axis_tdata[29:20];
  assign slope     = s_axis_tdata[60:45];
  // bias negatives so the shift truncates toward zero
  assign slope_adj = $signed({slope[15], slope}) + (slope[15] ? 17'sd7 : 17'sd0);
  assign err_d     = $signed({1'b0, sp}) - $signed({1'b0, tout});
  assign rise_d    = $signed({1'b0, sp}) - $signed({1'b0, tin});

  logic signed [10:0] err_q, rise_q;
  logic signed [12:0] slope8_q;
  logic [14:0]        flow_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      err_q    <= err_d;
      rise_q   <= rise_d;
      slope8_q <= slope_adj[15:3];
      flow_q   <= s_axis_tdata[44:30];
    end
  end

  // state
  logic [6:0]         off_q, ceil_q, pid_q;
  logic signed [15:0] isum_q, prev_q;

  // working registers
  logic [whpc_pkg::ACC_W-1:0]  acc_q;
  logic [whpc_pkg::TOP_W-1:0]  prop_q, integ_q;
  logic [6:0]                  term_q;
  logic signed [whpc_pkg::WK_W-1:0] total_q;

  // dead zone and pid limit
  logic signed [11:0] err_w, dz_w;
  logic signed [10:0] errz;
  logic signed [11:0] diff;
  logic signed [7:0]  lim_raw;
  logic [6:0]         limit;
  logic [whpc_pkg::TOP_W-1:0] top;

  assign err_w   = {err_q[10], err_q};
  assign dz_w    = $signed({6'b0, dead_zone_q});
  assign errz    = (err_w >= -dz_w && err_w <= dz_w) ? 11'sd0 : err_q;
  assign diff    = $signed({errz[10], errz}) - prev_q[11:0];
  assign lim_raw = $signed({1'b0, ceil_q}) - $signed({1'b0, off_q});
  assign limit   = lim_raw[7] ? 7'd0 : lim_raw[6:0];
  // limit times 100 as shifts
  assign top     = ({7'b0, limit} << 6) + ({7'b0, limit} << 5) + ({7'b0, limit} << 2);

  // shared multiplier operands
  logic signed [whpc_pkg::A_W-1:0] op_a;
  logic signed [B_W-1:0]           op_b;
  logic signed [P_W-1:0]           prod;

  always_comb begin
    case (ctrl.mul_sel)
      whpc_pkg::MS_FLOW: begin
        op_a = $signed({{(whpc_pkg::A_W-15){1'b0}}, flow_q});
        op_b = $signed({{(B_W-10){1'b0}}, rise_q[9:0]});
      end
      whpc_pkg::MS_GAIN_P: begin
        op_a = $signed({{(whpc_pkg::A_W-11){errz[10]}}, errz});
        op_b = $signed({{(B_W-8){1'b0}}, gain_p_q});
      end
      whpc_pkg::MS_COEF: begin
        op_a = $signed({1'b0, acc_q});
        op_b = $signed(low_volt_q ? COEF_HI : COEF_LO);
      end
      whpc_pkg::MS_GAIN_I: begin
        op_a = $signed({{(whpc_pkg::A_W-11){errz[10]}}, errz});
        op_b = $signed({{(B_W-8){1'b0}}, gain_i_q});
      end
      whpc_pkg::MS_GAIN_D: begin
        op_a = $signed({{(whpc_pkg::A_W-12){diff[11]}}, diff});
        op_b = $signed({{(B_W-8){1'b0}}, gain_d_q});
      end
      whpc_pkg::MS_RECIP: begin
        op_a = $signed({{(whpc_pkg::A_W-whpc_pkg::TOP_W){1'b0}},
                        total_q[whpc_pkg::TOP_W-1:0]});
        op_b = $signed(B_W'(whpc_pkg::RECIP_100));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  whpc_mul #(
    .A_W (whpc_pkg::A_W),
    .B_W (B_W)
  ) u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  whpc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer),
    .pid_en_i   (pid_en_q),
    .out_busy_i (m_axis_tvalid && !m_axis_tready),
    .ctrl_o     (ctrl)
  );

  // step results
  logic signed [whpc_pkg::WK_W-1:0] prod_w, top_w, prop_w, integ_w, integ_raw, integ_sum;
  logic [whpc_pkg::ACC_W-1:0]       acc_d;
  logic [whpc_pkg::TOP_W-1:0]       prop_d, integ_d;
  logic [TS_W-1:0]                  term_sum, term_sh;
  logic [6:0]                       term_d, pid_d;

  assign prod_w  = prod[whpc_pkg::WK_W-1:0];
  assign top_w   = $signed({{(whpc_pkg::WK_W-whpc_pkg::TOP_W){1'b0}}, top});
  assign prop_w  = $signed({{(whpc_pkg::WK_W-whpc_pkg::TOP_W){1'b0}}, prop_q});
  assign integ_w = $signed({{(whpc_pkg::WK_W-whpc_pkg::TOP_W){1'b0}}, integ_q});

  // flow times rise saturates well above the point where the term caps at 100
  assign acc_d = (|prod[P_W-1:whpc_pkg::ACC_W]) ? '1 : prod[whpc_pkg::ACC_W-1:0];

  assign prop_d = (prod_w < 0)     ? '0  :
                  (prod_w > top_w) ? top : prod_w[whpc_pkg::TOP_W-1:0];

  assign term_sum = {1'b0, prod} + (low_volt_q ? CST_HI : CST_LO);
  assign term_sh  = term_sum >> COEF_FRAC_BITS;
  assign term_d   = (term_sh > TS_W'(whpc_pkg::POWER_MAX)) ? whpc_pkg::POWER_MAX
                                                            : term_sh[6:0];

  // anti-windup
  assign integ_raw = $signed({{(whpc_pkg::WK_W-16){isum_q[15]}}, isum_q}) + prod_w;
  assign integ_sum = integ_raw + prop_w;
  assign integ_d   = (integ_sum > top_w) ? (top - prop_q) :
                     (integ_sum < 0)     ? '0 : integ_raw[whpc_pkg::TOP_W-1:0];

  // sum / 100 toward zero then clamp to 0..limit
  assign pid_d = (total_q <= 0)     ? 7'd0  :
                 (total_q >= top_w) ? limit :
                 prod[whpc_pkg::RECIP_SHIFT+6:whpc_pkg::RECIP_SHIFT];

  // offset update
  logic [7:0] off_sum, ceil_raw;
  logic [6:0] off_half;
  assign off_sum  = {1'b0, off_q} + {1'b0, term_q};
  assign off_half = off_sum[7:1];
  assign ceil_raw = {1'b0, off_half} + {2'b0, off_half[6:1]} + whpc_pkg::CEIL_BIAS;

  // output power
  logic signed [13:0] pw_sum, pw_ff, pw_band;
  logic [6:0]         pw_lo, pw_d;
  logic               band_pid, band_ff;

  assign band_pid = err_q > whpc_pkg::BAND_PID;
  assign band_ff  = err_q > whpc_pkg::BAND_FF;
  assign pw_ff    = $signed({7'b0, off_q}) + $signed({slope8_q[12], slope8_q});
  assign pw_sum   = pw_ff + $signed({7'b0, pid_q});
  assign pw_band  = band_pid ? pw_sum : (band_ff ? pw_ff : 14'sd0);
  // negative sums give 0
  assign pw_lo    = (pw_band < 0) ? 7'd0 :
                    (pw_band > $signed({7'b0, ceil_q})) ? ceil_q : pw_band[6:0];
  assign pw_d     = (pw_lo > whpc_pkg::POWER_MAX) ? whpc_pkg::POWER_MAX : pw_lo;

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_acc)   acc_q   <= acc_d;
    if (ctrl.ld_prop)  prop_q  <= prop_d;
    if (ctrl.ld_term)  term_q  <= term_d;
    if (ctrl.ld_integ) integ_q <= integ_d;
    if (ctrl.ld_total) total_q <= prop_w + integ_w + prod_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= '0;
      ceil_q <= '0;
      pid_q  <= '0;
      isum_q <= '0;
      prev_q <= '0;
    end else begin
      if (in_xfer && !pid_en_q) begin
        pid_q <= '0;
      end else if (ctrl.ld_pid) begin
        pid_q  <= pid_d;
        isum_q <= $signed({2'b0, integ_q});
        prev_q <= $signed({{5{errz[10]}}, errz});
      end else if (ctrl.ld_out && !band_ff) begin
        // cold band clears the pid
        pid_q  <= '0;
        isum_q <= '0;
      end
      if (ctrl.ld_off) begin
        if (rise_q < whpc_pkg::RISE_MIN) begin
          off_q  <= '0;
          ceil_q <= '0;
        end else if (off_half > whpc_pkg::OFFSET_MAX) begin
          off_q  <= whpc_pkg::OFFSET_MAX;
          ceil_q <= whpc_pkg::POWER_MAX;
        end else begin
          off_q  <= off_half;
          ceil_q <= (ceil_raw > {1'b0, whpc_pkg::POWER_MAX}) ? whpc_pkg::POWER_MAX
                                                               : ceil_raw[6:0];
        end
      end
    end
  end

  // output register
  logic       m_valid_q;
  logic [6:0] hp_q, ol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctrl.ld_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_out) begin
      hp_q <= pw_d;
      ol_q <= off_q;
    end
  end

  assign s_axis_tready = ctrl.in_ready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b0, ol_q, hp_q};

  // checks
  a_power_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[6:0] <= whpc_pkg::POWER_MAX))
    else $error("heater power above full scale");

  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (off_q <= whpc_pkg::OFFSET_MAX) && (ceil_q <= whpc_pkg::POWER_MAX))
    else $error("offset or ceiling out of range");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again while an item is in work");

  a_result_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(ctrl.ld_out))
    else $error("result valid without a sequencer output step");

endmodule
